// ===== sv/ghi_pkg.sv =====
// Shared types and constants for the gyro heading integrator.
package ghi_pkg;

	localparam int RATE_W   = 16;
	localparam int SCALED_W = 24;
	localparam int SUM_W    = 64;
	localparam int CAL_W    = 8;
	localparam int ODIV_W   = 20;
	localparam int CODE_W   = 10;
	localparam int APB_AW   = 4;
	localparam int APB_DW   = 32;

	localparam logic signed [7:0]   RATE_SCALE = 8'sd100;
	localparam logic [CODE_W-1:0]   CODE_MAX   = 10'd1023;

	localparam logic [CAL_W-1:0]    CAL_SAMPLES_RST = 8'd50;
	localparam logic [ODIV_W-1:0]   ODIV_RST        = 20'd48000;
	localparam logic [CODE_W-1:0]   CENTER_RST      = 10'd512;

	typedef enum logic [1:0] {
		REG_CAL_SAMPLES = 2'd0,
		REG_OUT_DIVISOR = 2'd1,
		REG_OUT_CENTER  = 2'd2,
		REG_UNUSED      = 2'd3
	} reg_idx_t;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_INTEG = 6'b000010,
		S_BIAS  = 6'b000100,
		S_DIVST = 6'b001000,
		S_DIVW  = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

endpackage

// ===== sv/ghi_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module ghi_div
	import ghi_pkg::*;
#(
	parameter int NUM_W = 64,
	parameter int DEN_W = 36
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient,
	output logic [DEN_W-1:0] remainder
);

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] work_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   rem_shift;
	logic [DEN_W+1:0] diff;
	logic             ge;

	assign rem_shift = {rem_q, work_q[NUM_W-1]};
	assign diff      = {1'b0, rem_shift} - {2'b00, den_q};
	assign ge        = !diff[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			den_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[NUM_W-2:0], ge};
			rem_q  <= ge ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = work_q;
	assign remainder = rem_q;

endmodule

// ===== sv/gyro_heading_integrator_with_bias_cal_unit.sv =====
// Top level of the gyro heading integrator with bias calibration.
//
// Input channel: one signed rate sample and a restart flag per transfer
// (in_valid / in_stall). Output channel: one heading code per transfer
// (out_valid / out_stall), given for every sample outside calibration.
// A sample that falls inside calibration and does not end it passes the integrate step and goes back to idle.
// A sample that ends calibration, or any sample outside it, runs through the
// shared 64-step divider (bias = -sum/count, or sum over the scaled output
// divisor). A sample that ends calibration steps through integrate, divider
// start, divider wait and final; a sample outside it adds a bias step before
// the divider, so that divider sets the rate.
// in_stall stays high while a sample is in work. The result sits in an
// output register; a new sample is accepted while it waits. If the receiver
// still stalls when the next result is ready, the block holds in its final
// step until the register frees up.
// Reset clears the heading, bias, calibration state and output valid, and
// loads the register defaults (50 samples, divisor 48000, center 512).
// Registers sit on an APB port at byte addresses 0, 4 and 8; the user must write
// them only while the block is idle, which the block itself does not enforce.
module gyro_heading_integrator_with_bias_cal_unit
	import ghi_pkg::*;
#(
	parameter int FRACTION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_AW-1:0]        paddr,
	input  logic [APB_DW-1:0]        pwdata,
	output logic [APB_DW-1:0]        prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [RATE_W-1:0] rate_sample,
	input  logic                     restart,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [CODE_W-1:0]        heading_code
);

	localparam int DEN_W = ODIV_W + FRACTION_BITS;

	logic [CAL_W-1:0]  cal_samples_q;
	logic [ODIV_W-1:0] odiv_q;
	logic [CODE_W-1:0] center_q;

	state_t                      state_q;
	logic                        cal_q;
	logic [CAL_W-1:0]            prog_q;
	logic [SUM_W-1:0]            sum_q;
	logic [SUM_W-1:0]            bias_q;
	logic signed [SCALED_W-1:0]  prev_q;
	logic signed [SCALED_W-1:0]  scaled_q;
	logic                        out_valid_q;
	logic [CODE_W-1:0]           code_q;

	logic                        in_xfer;
	logic                        out_free;
	logic                        fin_emit;
	logic                        cfg_wr;
	reg_idx_t                    cfg_idx;
	logic signed [SCALED_W-1:0]  scaled_d;
	logic signed [SCALED_W:0]    pair_sum;
	logic [SUM_W-1:0]            ave;
	logic [CAL_W-1:0]            prog_next;
	logic                        sum_neg;
	logic [SUM_W-1:0]            sum_mag;
	logic [ODIV_W-1:0]           odiv_eff;
	logic [DEN_W-1:0]            den;
	logic                        div_start;
	logic                        div_done;
	logic [SUM_W-1:0]            quot;
	logic [DEN_W-1:0]            rem;
	logic                        q_big;
	logic [CODE_W:0]             pos_sum;
	logic [CODE_W:0]             neg_q;
	logic [CODE_W-1:0]           code_d;

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_samples_q <= CAL_SAMPLES_RST;
			odiv_q        <= ODIV_RST;
			center_q      <= CENTER_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_CAL_SAMPLES: cal_samples_q <= pwdata[CAL_W-1:0];
				REG_OUT_DIVISOR: odiv_q        <= pwdata[ODIV_W-1:0];
				REG_OUT_CENTER:  center_q      <= pwdata[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_CAL_SAMPLES: prdata = APB_DW'(cal_samples_q);
			REG_OUT_DIVISOR: prdata = APB_DW'(odiv_q);
			REG_OUT_CENTER:  prdata = APB_DW'(center_q);
			default:         prdata = '0;
		endcase
	end

	// Datapath terms.
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign fin_emit  = (state_q == S_FIN) && !cal_q && out_free;
	assign scaled_d  = SCALED_W'(rate_sample) * SCALED_W'(RATE_SCALE);
	assign pair_sum  = (SCALED_W+1)'(scaled_q) + (SCALED_W+1)'(prev_q);

	// The mean of two scaled samples is exact with one fraction bit less.
	assign ave = (prev_q == '0) ? (SUM_W'(scaled_q) << FRACTION_BITS)
	                            : (SUM_W'(pair_sum) << (FRACTION_BITS - 1));

	assign prog_next = prog_q + 1'b1;
	assign sum_neg   = sum_q[SUM_W-1];
	assign sum_mag   = sum_neg ? (SUM_W'(0) - sum_q) : sum_q;
	assign odiv_eff  = (odiv_q == '0) ? ODIV_W'(1) : odiv_q;

	// A progress count of zero stands for 256 samples.
	assign den = cal_q ? DEN_W'({prog_q == '0, prog_q})
	                   : {odiv_eff, {FRACTION_BITS{1'b0}}};

	assign div_start = (state_q == S_DIVST);

	ghi_div #(
		.NUM_W (SUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (sum_mag),
		.divisor   (den),
		.done      (div_done),
		.quotient  (quot),
		.remainder (rem)
	);

	// Negative totals round toward minus infinity before the center offset.
	assign q_big   = |quot[SUM_W-1:CODE_W];
	assign pos_sum = {1'b0, quot[CODE_W-1:0]} + {1'b0, center_q};
	assign neg_q   = {1'b0, quot[CODE_W-1:0]} + (CODE_W+1)'(|rem);

	always_comb begin
		if (!sum_neg) begin
			if (q_big || pos_sum > {1'b0, CODE_MAX})
				code_d = CODE_MAX;
			else
				code_d = pos_sum[CODE_W-1:0];
		end else begin
			if (q_big || neg_q >= {1'b0, center_q})
				code_d = '0;
			else
				code_d = center_q - neg_q[CODE_W-1:0];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cal_q       <= 1'b0;
			prog_q      <= '0;
			sum_q       <= '0;
			bias_q      <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_emit)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (restart) begin
							sum_q  <= '0;
							prog_q <= '0;
							cal_q  <= 1'b1;
						end
						state_q <= S_INTEG;
					end
				end
				S_INTEG: begin
					sum_q  <= sum_q + ave;
					prev_q <= scaled_q;
					if (cal_q) begin
						if (prog_q == '0)
							bias_q <= '0;
						prog_q <= prog_next;
						state_q <= (prog_next == cal_samples_q) ? S_DIVST : S_IDLE;
					end else begin
						state_q <= S_BIAS;
					end
				end
				S_BIAS: begin
					sum_q   <= sum_q + bias_q;
					state_q <= S_DIVST;
				end
				S_DIVST: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_done)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (cal_q) begin
						bias_q  <= sum_neg ? quot : (SUM_W'(0) - quot);
						sum_q   <= '0;
						cal_q   <= 1'b0;
						state_q <= S_IDLE;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer)
			scaled_q <= scaled_d;
		if (fin_emit)
			code_q <= code_d;
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign heading_code = code_q;

endmodule

// ===== sv/ghi_checker.sv =====
// Port-level checks for the gyro heading integrator, bound to the top level.
module ghi_checker
	import ghi_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [CODE_W-1:0] heading_code
);

	// An accepted sample stalls the input, so no two samples are taken back to back.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted again right after a transfer");

	// A new result only appears at the end of a sample's work.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a sample in work");

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(heading_code))
		else $error("stalled result changed or dropped");

endmodule

bind gyro_heading_integrator_with_bias_cal_unit ghi_checker u_ghi_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for the gyro heading integrator with bias calibration.
import ghi_pkg::*;

localparam int FRAC_BITS = 16;

class heading_tracker;
	logic [CAL_W-1:0]  cal_samples;
	logic [ODIV_W-1:0] out_divisor;
	logic [CODE_W-1:0] out_center;
	bit                calibrating;
	logic [CAL_W-1:0]  progress;
	logic [SUM_W-1:0]  heading_sum;
	logic [SUM_W-1:0]  rate_bias;
	int                prev_scaled;
	logic [CODE_W-1:0] due_codes[$];
	int                failures;

	function new();
		cal_samples = CAL_SAMPLES_RST;
		out_divisor = ODIV_RST;
		out_center = CENTER_RST;
		calibrating = 0;
		progress = '0;
		heading_sum = '0;
		rate_bias = '0;
		prev_scaled = 0;
		failures = 0;
	endfunction

	function void set_register(reg_idx_t idx, logic [APB_DW-1:0] value);
		case (idx)
			REG_CAL_SAMPLES: cal_samples = value[CAL_W-1:0];
			REG_OUT_DIVISOR: out_divisor = value[ODIV_W-1:0];
			REG_OUT_CENTER:  out_center = value[CODE_W-1:0];
			default: ;
		endcase
	endfunction

	// The mean of two scaled samples is their sum at one fraction bit less.
	function void accumulate(int scaled, bit with_bias);
		longint step_val;
		if (prev_scaled == 0)
			step_val = longint'(scaled) <<< FRAC_BITS;
		else
			step_val = (longint'(scaled) + longint'(prev_scaled)) <<< (FRAC_BITS - 1);
		heading_sum += step_val;
		if (with_bias)
			heading_sum += rate_bias;
		prev_scaled = scaled;
	endfunction

	function void close_calibration();
		logic [SUM_W-1:0] cnt;
		logic [SUM_W-1:0] mag;
		logic [SUM_W-1:0] q;
		bit neg;
		cnt = (progress == 0) ? 64'd256 : 64'(progress);
		neg = heading_sum[SUM_W-1];
		mag = neg ? -heading_sum : heading_sum;
		q = mag / cnt;
		rate_bias = neg ? q : -q;
		heading_sum = '0;
		calibrating = 0;
	endfunction

	function logic [CODE_W-1:0] code_of();
		logic [SUM_W-1:0] div;
		logic [SUM_W-1:0] mag;
		logic [SUM_W-1:0] q;
		bit neg;
		div = (out_divisor == 0) ? 64'd1 : 64'(out_divisor);
		div = div << FRAC_BITS;
		neg = heading_sum[SUM_W-1];
		mag = neg ? -heading_sum : heading_sum;
		q = mag / div;
		if (!neg) begin
			if (q >= 1023)
				return CODE_MAX;
			q += out_center;
			return (q > 1023) ? CODE_MAX : q[CODE_W-1:0];
		end
		// Negative totals round away from zero, so the quotient magnitude rounds up.
		if (mag % div != 0)
			q += 1;
		if (q >= out_center)
			return '0;
		return out_center - q[CODE_W-1:0];
	endfunction

	function void take_sample(logic signed [RATE_W-1:0] rate, bit restart);
		int scaled;
		scaled = int'(rate) * 100;
		if (restart) begin
			heading_sum = '0;
			progress = '0;
			calibrating = 1;
		end
		if (calibrating) begin
			if (progress == 0)
				rate_bias = '0;
			accumulate(scaled, 0);
			progress = progress + 1'b1;
			if (progress == cal_samples)
				close_calibration();
			return;
		end
		accumulate(scaled, 1);
		due_codes.push_back(code_of());
	endfunction

	function void match_code(logic [CODE_W-1:0] code);
		logic [CODE_W-1:0] want;
		if (due_codes.size() == 0) begin
			$error("heading_code: expected none, actual %0d", code);
			failures++;
			return;
		end
		want = due_codes.pop_front();
		if (code !== want) begin
			$error("heading_code: expected %0d, actual %0d", want, code);
			failures++;
		end
	endfunction

	function int pending();
		return due_codes.size();
	endfunction
endclass

module testbench;
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_CYCLES   = 400;
	localparam int IDLE_LIMIT    = 3000;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_AW-1:0]        paddr;
	logic [APB_DW-1:0]        pwdata;
	logic [APB_DW-1:0]        prdata;
	logic                     pready;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [RATE_W-1:0] rate_sample;
	logic                     restart;
	logic                     out_valid;
	logic                     out_stall;
	logic [CODE_W-1:0]        heading_code;

	heading_tracker tracker;
	bit             no_idle;
	bit             hold_request;
	int             idle_cycles;

	gyro_heading_integrator_with_bias_cal_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rate_sample(rate_sample),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.heading_code(heading_code)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.match_code(heading_code);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver side: random stalls per transfer, plus one long hold on request.
	initial begin : receiver
		int wait_n;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				wait_n = HOLD_CYCLES;
				hold_request = 0;
			end else begin
				wait_n = no_idle ? 0 : $urandom_range(0, 12);
			end
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Valid is left high after a transfer so back-to-back samples need no gap.
	task automatic push_sample(input logic signed [RATE_W-1:0] rate, input bit rst);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rate_sample <= rate;
		restart <= rst;
		do @(posedge clk); while (in_stall);
		tracker.take_sample(rate, rst);
	endtask

	task automatic drain_codes();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() > 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.set_register(idx, value);
	endtask

	// A calibration sample gives no result, so the block may still be busy
	// after the last code; let it settle before touching the registers.
	task automatic program_regs(input int cal, input int div, input int center);
		drain_codes();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_CAL_SAMPLES, cal);
		write_reg(REG_OUT_DIVISOR, div);
		write_reg(REG_OUT_CENTER, center);
	endtask

	function automatic logic signed [RATE_W-1:0] draw_rate(int drift);
		int pick;
		int v;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			v = drift + int'($urandom_range(0, 400)) - 200;
		else if (pick < 62)
			v = 0;
		else if (pick < 80)
			v = int'($urandom_range(0, 65535)) - 32768;
		else if (pick < 90)
			v = $urandom_range(0, 1) ? 32767 : -32768;
		else
			v = $urandom_range(0, 1) ? 1 : -1;
		return RATE_W'(v);
	endfunction

	// One session: program the registers, optionally restart into calibration,
	// then stream samples, many around a constant drift, with optional restarts.
	task automatic run_session(input int cal, input int div, input int center, input int n,
			input int restart_odds, input bit first_restart, input int hold_at,
			input int pause_at);
		int i;
		int drift;
		bit rst;
		drift = int'($urandom_range(0, 2000)) - 1000;
		program_regs(cal, div, center);
		for (i = 0; i < n; i++) begin
			if (i == hold_at)
				hold_request = 1;
			if (i == pause_at)
				drain_codes();
			if (i == 0)
				rst = first_restart;
			else
				rst = (restart_odds > 0) && ($urandom_range(1, restart_odds) == 1);
			push_sample(draw_rate(drift), rst);
		end
	endtask

	initial begin
		tracker = new();
		no_idle = 0;
		hold_request = 0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		rate_sample <= '0;
		restart <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults, not calibrating: extremes and the zero-previous path.
		push_sample(32767, 0);
		push_sample(32767, 0);
		push_sample(-32768, 0);
		push_sample(0, 0);
		push_sample(0, 0);
		push_sample(100, 0);
		push_sample(-1, 0);

		// Short calibration with a unit divisor to reach both saturation ends.
		program_regs(3, 1, 0);
		push_sample(500, 1);
		push_sample(600, 0);
		push_sample(700, 0);
		push_sample(32767, 0);
		push_sample(-32768, 0);
		push_sample(0, 0);

		// Zero divisor, and a restart in the middle of calibration.
		program_regs(5, 0, 1023);
		push_sample(10, 1);
		push_sample(20, 0);
		push_sample(30, 1);
		push_sample(40, 0);
		push_sample(50, 0);
		push_sample(60, 0);
		push_sample(70, 0);
		push_sample(-5, 0);
		push_sample(5, 0);

		run_session(1, 1, 512, 40, 20, 1, 10, -1);
		run_session(12, 1000000, 0, 24, 0, 1, -1, -1);
		// A zero sample count wraps, so calibration runs for 256 samples.
		run_session(0, 20'hFFFFF, 1023, 262, 0, 1, -1, -1);
		run_session($urandom_range(2, 20), 48000, 512, 30, 25, 1, -1, 15);
		no_idle = 1;
		run_session($urandom_range(1, 10), $urandom_range(100, 5000),
				$urandom_range(0, 1023), 25, 15, 1, -1, -1);
		no_idle = 0;
		run_session($urandom_range(1, 255), $urandom_range(1, 1000000),
				$urandom_range(0, 1023), 25, 30, 0, -1, -1);

		drain_codes();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.pending() != 0) begin
			$error("heading_code: %0d expected results never arrived", tracker.pending());
			tracker.failures++;
		end
		if (tracker.failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
